// ----- src/pms_pkg.sv -----
// ============================================================================
// pms_pkg: shared types and constants for the pointer motion to scroll block
// Word formats, command codes, thresholds and small arithmetic helpers.
// ============================================================================
package pms_pkg;

    localparam int MOTION_W = 16;
    localparam int SCROLL_W = 24;
    localparam int TIME_W   = 32;
    localparam int SUM_W    = 32;
    localparam int MAG_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 1;

    // Input word kinds.
    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_MOTION = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    // Output word kinds.
    localparam logic OUT_SCROLL = 1'b0;
    localparam logic OUT_CLICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE_VERTICAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE_HORIZONTAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_FIXATION    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_VERTICAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_HORIZONTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE_MOMENTUM   = 3'd5;

    localparam logic [SUM_W-1:0]  CLICK_TRAVEL_MAX = 32'd5;
    localparam logic [TIME_W-1:0] CLICK_TIME_MS    = 32'd300;
    localparam logic [TIME_W-1:0] MOTION_GAP_MS    = 32'd100;
    localparam logic [TIME_W-1:0] FIX_IDLE_MS      = 32'd300;
    localparam logic [TIME_W-1:0] FIX_EARLY_MS     = 32'd1000;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [MOTION_W-1:0] dx;
        logic signed [MOTION_W-1:0] dy;
        logic [TIME_W-1:0]          now_ms;
    } in_word_t;

    typedef struct packed {
        logic                       out_kind;
        logic signed [SCROLL_W-1:0] scroll_vertical;
        logic signed [SCROLL_W-1:0] scroll_horizontal;
    } out_word_t;

    // One operation on the scroll queue per cycle.
    typedef struct packed {
        logic                       clear;
        logic                       push;
        logic                       pop;
        logic                       momentum;
        logic signed [SCROLL_W-1:0] push_vertical;
        logic signed [SCROLL_W-1:0] push_horizontal;
    } fifo_cmd_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SCROLL_W-1:0] vertical;
        logic signed [SCROLL_W-1:0] horizontal;
    } fifo_resp_t;

    // Negation that maps the most negative value to the most positive one.
    function automatic logic signed [MOTION_W-1:0] neg_sat(input logic signed [MOTION_W-1:0] v);
        logic signed [MOTION_W-1:0] r;
        if (v == {1'b1, {(MOTION_W-1){1'b0}}})
            r = {1'b0, {(MOTION_W-1){1'b1}}};
        else
            r = -v;
        return r;
    endfunction

    // Magnitude of a value that never holds the most negative code.
    function automatic logic [MAG_W-1:0] mag(input logic signed [MOTION_W-1:0] v);
        logic signed [MOTION_W-1:0] a;
        a = v[MOTION_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic opposite(input logic signed [MOTION_W-1:0] a,
                                      input logic signed [MOTION_W-1:0] b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // Halving that truncates toward zero.
    function automatic logic signed [SCROLL_W-1:0] half(input logic signed [SCROLL_W-1:0] v);
        logic [SCROLL_W-1:0] t;
        t = v + SCROLL_W'(v[SCROLL_W-1]);
        return {t[SCROLL_W-1], t[SCROLL_W-1:1]};
    endfunction

endpackage

// ----- src/pms_stream_if.sv -----
// ============================================================================
// pms_stream_if: valid/ready channel
// Carries one word of the given payload type per handshake.
// ============================================================================
interface pms_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/pointer_motion_to_scroll.sv -----
// ============================================================================
// pointer_motion_to_scroll: relative pointer motion to scroll-wheel deltas
// Applies axis disables, axis and fixation locks, holds the dominant delta,
// queues scaled deltas and emits them on scroll ticks, with optional momentum.
// ============================================================================
//
//  channel   dir  handshake        contents
//  --------  ---  ---------------  ----------------------------------------
//  in_ch     in   valid/ready      kind, dx, dy, now_ms
//  out_ch    out  valid/ready      out_kind, scroll_vertical, scroll_horizontal
//  cfg       in   cfg_write_en     cfg_index selects a one-bit register
//
// One word is accepted per cycle while the input is not stalled. An accepted
// word is registered in the front stage, and any result word that it yields is
// then written to the output buffer, from which out_ch presents it.
// The pipeline is a stateless front stage (negation, disables, axis lock)
// and a state stage that updates the gesture registers and runs one queue
// operation on the delta RAM; the RAM head is read ahead so pops do not stall.
// An output buffer of two words decouples the sink; the input stalls only
// when both buffer words are occupied and the front stage holds a word.
// Reset clears all control state at once; queue RAM contents need no clearing
// because an entry is never read before it has been written.
// ============================================================================
module pointer_motion_to_scroll #(
    parameter int FIFO_DEPTH   = 16,
    parameter int SCROLL_SCALE = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pms_stream_if.sink                          in_ch,
    pms_stream_if.source                        out_ch,
    input  logic                                cfg_write_en,
    input  logic [pms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int MW = pms_pkg::MOTION_W;
    localparam int SW = pms_pkg::SCROLL_W;
    localparam int TW = pms_pkg::TIME_W;
    localparam int UW = pms_pkg::SUM_W;
    localparam int AW = pms_pkg::MAG_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic dis_v_reg, dis_h_reg, en_fix_reg, rev_v_reg, rev_h_reg, dis_mom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dis_v_reg   <= 1'b0;
            dis_h_reg   <= 1'b0;
            en_fix_reg  <= 1'b0;
            rev_v_reg   <= 1'b0;
            rev_h_reg   <= 1'b0;
            dis_mom_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                pms_pkg::REG_DISABLE_VERTICAL:   dis_v_reg   <= cfg_data[0];
                pms_pkg::REG_DISABLE_HORIZONTAL: dis_h_reg   <= cfg_data[0];
                pms_pkg::REG_ENABLE_FIXATION:    en_fix_reg  <= cfg_data[0];
                pms_pkg::REG_REVERSE_VERTICAL:   rev_v_reg   <= cfg_data[0];
                pms_pkg::REG_REVERSE_HORIZONTAL: rev_h_reg   <= cfg_data[0];
                pms_pkg::REG_DISABLE_MOMENTUM:   dis_mom_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front stage: per-word motion shaping, no gesture state involved.
    // ------------------------------------------------------------------
    pms_pkg::in_word_t in_word;
    logic              in_fire, b_fire;

    logic                 a_valid_reg, a_valid_next;
    logic [1:0]           a_kind_reg;
    logic [TW-1:0]        a_now_reg;
    logic signed [MW-1:0] a_dv_reg, a_dh_reg;
    logic [AW-1:0]        a_av_reg, a_ah_reg;

    logic signed [MW-1:0] f_dv, f_dh, f_dv_lock, f_dh_lock;
    logic [AW-1:0]        f_av, f_ah;

    assign in_word     = in_ch.payload;
    assign in_ch.ready = !a_valid_reg || b_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        // Pointer motion to the right scrolls left, hence the negation.
        f_dv = dis_v_reg ? '0 : pms_pkg::neg_sat(in_word.dy);
        f_dh = dis_h_reg ? '0 : pms_pkg::neg_sat(in_word.dx);
        f_av = pms_pkg::mag(f_dv);
        f_ah = pms_pkg::mag(f_dh);
        // Axis lock: the weaker axis is dropped when the other one is more
        // than twice as large.
        f_dh_lock = ({1'b0, f_av} > {f_ah, 1'b0}) ? '0 : f_dh;
        f_dv_lock = ({1'b0, f_ah} > {f_av, 1'b0}) ? '0 : f_dv;
        a_valid_next = in_fire ? 1'b1 : (b_fire ? 1'b0 : a_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_kind_reg <= in_word.kind;
            a_now_reg  <= in_word.now_ms;
            a_dv_reg   <= f_dv_lock;
            a_dh_reg   <= f_dh_lock;
            a_av_reg   <= f_av;
            a_ah_reg   <= f_ah;
        end
    end

    // ------------------------------------------------------------------
    // State stage: gesture registers, fixation lock, held delta, queue.
    // ------------------------------------------------------------------
    logic [UW-1:0]        travel_reg, travel_next;
    logic [TW-1:0]        gstart_reg, gstart_next;
    logic [TW-1:0]        last_reg, last_next;
    logic signed [MW-1:0] held_v_reg, held_v_next, held_h_reg, held_h_next;
    logic [TW-1:0]        fix_last_reg, fix_last_next, fix_start_reg, fix_start_next;
    logic [UW-1:0]        fix_v_sum_reg, fix_v_sum_next, fix_h_sum_reg, fix_h_sum_next;

    logic                 is_begin, is_motion, gap, fix_restart, early, flip, grow;
    logic                 lock_h, lock_v;
    logic signed [MW-1:0] held_v_base, held_h_base, dv2, dh2;
    logic [UW-1:0]        travel_base, fvs_base, fhs_base;
    logic [TW-1:0]        fs_base;
    logic [AW:0]          held_mag_sum;
    logic [31:0]          scaled_v, scaled_h;

    pms_pkg::fifo_cmd_t   fifo_cmd;
    pms_pkg::fifo_resp_t  fifo_resp;

    logic                 b_result;
    pms_pkg::out_word_t   b_word;
    logic [1:0]           obuf_count_reg, obuf_count_next;

    assign b_fire = a_valid_reg && (obuf_count_reg != 2'd2);

    always_comb
    begin
        is_begin  = (a_kind_reg == pms_pkg::KIND_BEGIN);
        is_motion = is_begin || (a_kind_reg == pms_pkg::KIND_MOTION);

        // A gesture begin restarts the gesture, so it never sees a gap.
        gap         = !is_begin && ((a_now_reg - last_reg) > pms_pkg::MOTION_GAP_MS);
        held_v_base = (is_begin || gap) ? '0 : held_v_reg;
        held_h_base = (is_begin || gap) ? '0 : held_h_reg;
        travel_base = is_begin ? '0 : travel_reg;

        // Fixation: motion summed early in the gesture pins it to one axis.
        fix_restart = (a_now_reg - fix_last_reg) > pms_pkg::FIX_IDLE_MS;
        fs_base     = fix_restart ? a_now_reg : fix_start_reg;
        fvs_base    = fix_restart ? '0 : fix_v_sum_reg;
        fhs_base    = fix_restart ? '0 : fix_h_sum_reg;
        lock_h      = en_fix_reg && ({1'b0, fvs_base} > {fhs_base, 1'b0});
        lock_v      = en_fix_reg && ({1'b0, fhs_base} > {fvs_base, 1'b0});
        dh2         = lock_h ? '0 : a_dh_reg;
        dv2         = lock_v ? '0 : a_dv_reg;
        early       = (a_now_reg - fs_base) < pms_pkg::FIX_EARLY_MS;

        // A sign flip on either axis restarts the held delta and the queue;
        // otherwise the held delta only grows.
        flip = pms_pkg::opposite(dv2, held_v_base) || pms_pkg::opposite(dh2, held_h_base);
        grow = (pms_pkg::mag(dv2) > pms_pkg::mag(held_v_base)) ||
               (pms_pkg::mag(dh2) > pms_pkg::mag(held_h_base));

        travel_next    = travel_reg;
        gstart_next    = gstart_reg;
        last_next      = last_reg;
        held_v_next    = held_v_reg;
        held_h_next    = held_h_reg;
        fix_last_next  = fix_last_reg;
        fix_start_next = fix_start_reg;
        fix_v_sum_next = fix_v_sum_reg;
        fix_h_sum_next = fix_h_sum_reg;

        if (flip || grow)
        begin
            held_v_next = dv2;
            held_h_next = dh2;
        end
        else
        begin
            held_v_next = held_v_base;
            held_h_next = held_h_base;
        end
        held_mag_sum = {1'b0, pms_pkg::mag(held_v_next)} + {1'b0, pms_pkg::mag(held_h_next)};
        scaled_v     = 32'(held_v_next) * 32'(SCROLL_SCALE);
        scaled_h     = 32'(held_h_next) * 32'(SCROLL_SCALE);

        fifo_cmd.clear           = 1'b0;
        fifo_cmd.push            = 1'b0;
        fifo_cmd.pop             = 1'b0;
        fifo_cmd.momentum        = !dis_mom_reg;
        fifo_cmd.push_vertical   = scaled_v[SW-1:0];
        fifo_cmd.push_horizontal = scaled_h[SW-1:0];

        b_result               = 1'b0;
        b_word.out_kind        = pms_pkg::OUT_SCROLL;
        b_word.scroll_vertical   = rev_v_reg ? -fifo_resp.vertical : fifo_resp.vertical;
        b_word.scroll_horizontal = rev_h_reg ? -fifo_resp.horizontal : fifo_resp.horizontal;

        if (b_fire)
        begin
            if (is_motion)
            begin
                last_next   = a_now_reg;
                travel_next = pms_pkg::add_sat(travel_base, UW'(held_mag_sum));
                if (is_begin)
                begin
                    gstart_next = a_now_reg;
                end
                if (!flip && !grow)
                begin
                    held_v_next = held_v_base;
                    held_h_next = held_h_base;
                end
                if (en_fix_reg)
                begin
                    fix_last_next  = a_now_reg;
                    fix_start_next = fs_base;
                    fix_v_sum_next = (early && dh2 == '0) ?
                                     pms_pkg::add_sat(fvs_base, UW'(a_av_reg)) : fvs_base;
                    fix_h_sum_next = (early && dv2 == '0) ?
                                     pms_pkg::add_sat(fhs_base, UW'(a_ah_reg)) : fhs_base;
                end
                fifo_cmd.clear = gap || flip;
                fifo_cmd.push  = 1'b1;
            end
            else if (a_kind_reg == pms_pkg::KIND_END)
            begin
                fifo_cmd.clear = 1'b1;
                // A short, nearly still gesture counts as a click.
                if (travel_reg <= pms_pkg::CLICK_TRAVEL_MAX &&
                    (a_now_reg - gstart_reg) < pms_pkg::CLICK_TIME_MS)
                begin
                    b_result                 = 1'b1;
                    b_word.out_kind          = pms_pkg::OUT_CLICK;
                    b_word.scroll_vertical   = '0;
                    b_word.scroll_horizontal = '0;
                end
            end
            else
            begin
                fifo_cmd.pop = 1'b1;
                b_result     = fifo_resp.valid;
            end
        end
        else
        begin
            held_v_next = held_v_reg;
            held_h_next = held_h_reg;
        end

        if (b_fire && !is_motion)
        begin
            held_v_next = held_v_reg;
            held_h_next = held_h_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg    <= '0;
            gstart_reg    <= '0;
            last_reg      <= '0;
            held_v_reg    <= '0;
            held_h_reg    <= '0;
            fix_last_reg  <= '0;
            fix_start_reg <= '0;
            fix_v_sum_reg <= '0;
            fix_h_sum_reg <= '0;
        end
        else
        begin
            travel_reg    <= travel_next;
            gstart_reg    <= gstart_next;
            last_reg      <= last_next;
            held_v_reg    <= held_v_next;
            held_h_reg    <= held_h_next;
            fix_last_reg  <= fix_last_next;
            fix_start_reg <= fix_start_next;
            fix_v_sum_reg <= fix_v_sum_next;
            fix_h_sum_reg <= fix_h_sum_next;
        end
    end

    pms_scroll_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fifo_cmd),
        .resp  (fifo_resp)
    );

    // ------------------------------------------------------------------
    // Two-word output buffer.
    // ------------------------------------------------------------------
    pms_pkg::out_word_t obuf_reg [2];
    logic               obuf_wr_reg, obuf_rd_reg;
    logic               out_fire;

    assign out_ch.valid   = (obuf_count_reg != 2'd0);
    assign out_ch.payload = obuf_reg[obuf_rd_reg];
    assign out_fire       = out_ch.valid && out_ch.ready;

    always_comb
    begin
        obuf_count_next = obuf_count_reg + 2'(b_result) - 2'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_count_reg <= 2'd0;
            obuf_wr_reg    <= 1'b0;
            obuf_rd_reg    <= 1'b0;
        end
        else
        begin
            obuf_count_reg <= obuf_count_next;
            if (b_result)
            begin
                obuf_wr_reg <= !obuf_wr_reg;
            end
            if (out_fire)
            begin
                obuf_rd_reg <= !obuf_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_result)
        begin
            obuf_reg[obuf_wr_reg] <= b_word;
        end
    end

    a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_count_reg <= 2'd2)
        else $error("output buffer holds more than two words");

    a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> a_valid_reg)
        else $error("accepted word did not reach the front stage");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        b_result |=> out_ch.valid)
        else $error("result word not presented on the output");
endmodule

// ----- src/pms_ram.sv -----
// ============================================================================
// pms_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module pms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- src/pms_scroll_fifo.sv -----
// ============================================================================
// pms_scroll_fifo: queue of pending scroll deltas
// Circular queue in a RAM; the head entry is read ahead every cycle so that a
// pop sees its data at once, with a bypass for an entry written the cycle before.
// ============================================================================
module pms_scroll_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pms_pkg::fifo_cmd_t    cmd,
    output pms_pkg::fifo_resp_t   resp
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = pms_pkg::SCROLL_W;
    localparam int ENT_W = 2 * W;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             fwd_valid_reg, fwd_valid_next;
    logic [ENT_W-1:0] fwd_data_reg;

    logic [ENT_W-1:0]   rd_data, head_data, wr_data;
    logic signed [W-1:0] hd_v, hd_h;
    logic [PTR_W-1:0]   head_c, head_inc, slot;
    logic [CNT_W-1:0]   count_c;
    logic [CNT_W:0]     slot_sum;
    logic               we;

    pms_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_data = fwd_valid_reg ? fwd_data_reg : rd_data;
        hd_v      = head_data[ENT_W-1:W];
        hd_h      = head_data[W-1:0];

        head_c   = cmd.clear ? '0 : head_reg;
        count_c  = cmd.clear ? '0 : count_reg;
        slot_sum = (CNT_W+1)'(head_c) + (CNT_W+1)'(count_c);
        if (slot_sum >= (CNT_W+1)'(DEPTH))
            slot = PTR_W'(slot_sum - (CNT_W+1)'(DEPTH));
        else
            slot = PTR_W'(slot_sum);
        head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

        head_next  = head_c;
        count_next = count_c;
        we         = 1'b0;
        wr_data    = {cmd.push_vertical, cmd.push_horizontal};
        resp.valid      = 1'b0;
        resp.vertical   = hd_v;
        resp.horizontal = hd_h;

        if (cmd.push)
        begin
            if (count_c < CNT_W'(DEPTH))
            begin
                we         = 1'b1;
                count_next = count_c + 1'b1;
            end
        end
        else if (cmd.pop && count_reg != '0)
        begin
            resp.valid = 1'b1;
            head_next  = head_inc;
            // The popped slot frees one place, so the momentum entry always fits.
            if (cmd.momentum && (hd_v != '0 || hd_h != '0))
            begin
                we         = 1'b1;
                wr_data    = {pms_pkg::half(hd_v), pms_pkg::half(hd_h)};
                count_next = count_reg;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end

        fwd_valid_next = we && (slot == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("scroll queue count exceeds its depth");

    a_clear_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear && !cmd.push |=> count_reg == '0)
        else $error("scroll queue not empty after a clear");

    a_clear_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear && cmd.push |=> count_reg == CNT_W'(1))
        else $error("scroll queue should hold one entry after clear and push");

    a_plain_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop && count_reg != '0 && !we |=> count_reg == $past(count_reg) - 1'b1)
        else $error("scroll queue pop did not reduce the count");
endmodule
